@@ hdl/vptp_pkg.sv @@
package vptp_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_NORMAL_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_NORMAL_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_NORMAL_Z = 2'd2;

  // control that travels alongside each transaction
  typedef struct packed {
    logic valid;
    logic last;
    logic nn_zero;
  } ctrl_t;

endpackage

@@ hdl/vptp_in_if.sv @@
interface vptp_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] vec_x;
  logic signed [DATA_WIDTH-1:0] vec_y;
  logic signed [DATA_WIDTH-1:0] vec_z;
  logic                         in_last;

  modport source (output valid, vec_x, vec_y, vec_z, in_last, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, in_last, output ready);
endinterface

@@ hdl/vptp_out_if.sv @@
interface vptp_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] proj_x;
  logic signed [DATA_WIDTH-1:0] proj_y;
  logic signed [DATA_WIDTH-1:0] proj_z;
  logic                         out_last;

  modport source (output valid, proj_x, proj_y, proj_z, out_last, input ready);
  modport sink (input valid, proj_x, proj_y, proj_z, out_last, output ready);
endinterface

@@ hdl/vector_project_to_plane.sv @@
// Projects a stream of 3D vectors onto the plane through the origin whose
// normal is held in three registers (normal_x, normal_y, normal_z).
// in_ch carries vec_x/vec_y/vec_z and in_last; out_ch returns proj_x/y/z
// and out_last, all signed fixed point, saturated to DATA_WIDTH bits.
// Registers are written through cfg_we/cfg_idx/cfg_data; the user must write them only while idle (not enforced).
// Throughput: one transaction per cycle on both channels while out_ch is not stalled.
// Pipeline: the stages of products and sums, the stages of the pipelined
// restoring divider (one quotient bit per stage), one output register.
// A zero normal gives a zero result.
// Reset clears all valid bits and loads the normal with (1, 0, 0).
// When the receiver holds off ready while a result is shown, the whole
// pipeline freezes and in_ch.ready drops; nothing is lost or repeated,
// and it resumes as soon as the result is taken.
module vector_project_to_plane
  import vptp_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  vptp_in_if.sink               in_ch,
  vptp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_idx,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int QB = DW + 2;
  localparam int NB = 2 * DW;
  localparam int WB = 3 * DW + 2;
  localparam logic [QB-1:0] HalfRange = QB'(1) << (DW - 1);
  localparam logic [DW-1:0] MaxVal = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MinVal = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0] normal_x, normal_y, normal_z;
  logic                 en;
  ctrl_t                in_ctrl, front_ctrl, div_ctrl;
  ctrl_t                ctrl_pipe [QB+1];
  logic [NB-1:0]        rem [3];
  logic [QB-1:0]        num [3];
  logic                 neg [3];
  logic [NB-1:0]        den;
  logic [QB-1:0]        q [3];
  logic                 q_neg [3];
  logic [DW-1:0]        sat [3];
  logic                 out_zero;

  // stall the whole pipeline only when a result waits at the output
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // normal registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x <= DW'(1) << FRAC_BITS;
      normal_y <= '0;
      normal_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NORMAL_X: normal_x <= cfg_data;
        REG_NORMAL_Y: normal_y <= cfg_data;
        REG_NORMAL_Z: normal_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ctrl = '{valid: in_ch.valid, last: in_ch.in_last, nn_zero: 1'b0};

  vptp_front #(.DW(DW), .QB(QB), .NB(NB), .WB(WB)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctrl  (in_ctrl),
    .vx       (in_ch.vec_x),
    .vy       (in_ch.vec_y),
    .vz       (in_ch.vec_z),
    .nx       (normal_x),
    .ny       (normal_y),
    .nz       (normal_z),
    .out_ctrl (front_ctrl),
    .rem      (rem),
    .num      (num),
    .neg      (neg),
    .den      (den)
  );

  // one divider pipeline per component
  for (genvar c = 0; c < 3; c++) begin : g_div
    vptp_div #(.NB(NB), .QB(QB)) u_div (
      .clk     (clk),
      .en      (en),
      .rem_in  (rem[c]),
      .num_in  (num[c]),
      .den_in  (den),
      .neg_in  (neg[c]),
      .q_out   (q[c]),
      .neg_out (q_neg[c])
    );
  end

  // control follows the divider stages
  assign ctrl_pipe[0] = front_ctrl;
  for (genvar k = 0; k < QB; k++) begin : g_ctrl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_pipe[k+1] <= '0;
      end else if (en) begin
        ctrl_pipe[k+1] <= ctrl_pipe[k];
      end
    end
  end
  assign div_ctrl = ctrl_pipe[QB];

  // sign restore and saturation
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (div_ctrl.nn_zero) begin
        sat[c] = '0;
      end else if (q_neg[c]) begin
        sat[c] = (q[c] > HalfRange) ? MinVal : DW'(QB'(0) - q[c]);
      end else begin
        sat[c] = (q[c] >= HalfRange) ? MaxVal : q[c][DW-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= div_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.proj_x   <= sat[0];
      out_ch.proj_y   <= sat[1];
      out_ch.proj_z   <= sat[2];
      out_ch.out_last <= div_ctrl.last;
      out_zero        <= div_ctrl.nn_zero;
    end
  end

  // ready drops only behind a result that waits
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a waiting result");

  // an item leaving the divider reaches the output register
  a_div_to_out: assert property (@(posedge clk) disable iff (rst)
    (en && div_ctrl.valid) |=> out_ch.valid)
    else $error("item lost between divider and output");

  // zero normal always yields a zero vector
  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_zero) |->
      (out_ch.proj_x == '0 && out_ch.proj_y == '0 && out_ch.proj_z == '0))
    else $error("non-zero result for zero normal");

endmodule

@@ hdl/vptp_front.sv @@
module vptp_front
  import vptp_pkg::*;
#(
  parameter int DW = 32,
  parameter int QB = DW + 2,
  parameter int NB = 2 * DW,
  parameter int WB = 3 * DW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctrl_t                in_ctrl,
  input  logic signed [DW-1:0] vx,
  input  logic signed [DW-1:0] vy,
  input  logic signed [DW-1:0] vz,
  input  logic signed [DW-1:0] nx,
  input  logic signed [DW-1:0] ny,
  input  logic signed [DW-1:0] nz,
  output ctrl_t                out_ctrl,
  output logic [NB-1:0]        rem [3],
  output logic [QB-1:0]        num [3],
  output logic                 neg [3],
  output logic [NB-1:0]        den
);

  localparam int PW  = 2 * DW;
  localparam int NvW = 2 * DW + 1;

  logic signed [DW-1:0] v [3];
  logic signed [DW-1:0] n [3];

  assign v[0] = vx;
  assign v[1] = vy;
  assign v[2] = vz;
  assign n[0] = nx;
  assign n[1] = ny;
  assign n[2] = nz;

  ctrl_t s1_ctrl, s2_ctrl, s3_ctrl, s4_ctrl;

  logic signed [PW-1:0]  pnn [3];
  logic signed [PW-1:0]  pnv [3];
  logic signed [DW-1:0]  s1_v [3];
  logic [NB-1:0]         nn;
  logic signed [NvW-1:0] nv;
  logic signed [DW-1:0]  s2_v [3];
  logic signed [NvW-1:0] pv_lo [3];
  logic signed [NvW-1:0] pv_hi [3];
  logic signed [NvW-1:0] pn_lo [3];
  logic signed [NvW-1:0] pn_hi [3];
  logic [NB-1:0]         s3_nn;
  logic signed [WB-1:0]  w [3];
  logic [NB-1:0]         s4_nn;
  logic [WB-1:0]         abs_w [3];

  // control pipeline, nn zero flag joins after the sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl  <= '0;
      s2_ctrl  <= '0;
      s3_ctrl  <= '0;
      s4_ctrl  <= '0;
      out_ctrl <= '0;
    end else if (en) begin
      s1_ctrl  <= in_ctrl;
      s2_ctrl  <= s1_ctrl;
      s3_ctrl  <= '{valid: s2_ctrl.valid, last: s2_ctrl.last, nn_zero: (nn == '0)};
      s4_ctrl  <= s3_ctrl;
      out_ctrl <= s4_ctrl;
    end
  end

  // stage 1: component products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pnn[c]  <= n[c] * n[c];
        pnv[c]  <= n[c] * v[c];
        s1_v[c] <= v[c];
      end
    end
  end

  // stage 2: n.n and n.v
  always_ff @(posedge clk) begin
    if (en) begin
      nn   <= NB'(pnn[0]) + NB'(pnn[1]) + NB'(pnn[2]);
      nv   <= NvW'(pnv[0]) + NvW'(pnv[1]) + NvW'(pnv[2]);
      s2_v <= s1_v;
    end
  end

  // stage 3: partial products of v*nn and n*nv, split in halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pv_lo[c] <= s2_v[c] * $signed({1'b0, nn[DW-1:0]});
        pv_hi[c] <= s2_v[c] * $signed({1'b0, nn[NB-1:DW]});
        pn_lo[c] <= n[c] * $signed({1'b0, nv[DW-1:0]});
        pn_hi[c] <= n[c] * $signed(nv[NvW-1:DW]);
      end
      s3_nn <= nn;
    end
  end

  // stage 4: w = v(n.n) - n(n.v)
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        w[c] <= (WB'(pv_hi[c]) <<< DW) + WB'(pv_lo[c])
              - (WB'(pn_hi[c]) <<< DW) - WB'(pn_lo[c]);
      end
      s4_nn <= s3_nn;
    end
  end

  // stage 5: magnitude and sign, split into divider start remainder and low bits
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      abs_w[c] = w[c][WB-1] ? WB'(-w[c]) : WB'(w[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rem[c] <= abs_w[c][WB-1:QB];
        num[c] <= abs_w[c][QB-1:0];
        neg[c] <= w[c][WB-1];
      end
      den <= s4_nn;
    end
  end

endmodule

@@ hdl/vptp_div.sv @@
module vptp_div #(
  parameter int NB = 64,
  parameter int QB = 34
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] rem_in,
  input  logic [QB-1:0] num_in,
  input  logic [NB-1:0] den_in,
  input  logic          neg_in,
  output logic [QB-1:0] q_out,
  output logic          neg_out
);

  logic [NB-1:0] rem [QB+1];
  logic [QB-1:0] num [QB+1];
  logic [QB-1:0] q   [QB+1];
  logic [NB-1:0] den [QB+1];
  logic          neg [QB+1];

  assign rem[0] = rem_in;
  assign num[0] = num_in;
  assign q[0]   = '0;
  assign den[0] = den_in;
  assign neg[0] = neg_in;

  // one restoring step per stage, quotient bits shift in msb first
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NB:0] trial;
    logic        ge;

    assign trial = {rem[k], num[k][QB-1]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? NB'(trial - {1'b0, den[k]}) : trial[NB-1:0];
        num[k+1] <= num[k] << 1;
        q[k+1]   <= {q[k][QB-2:0], ge};
        den[k+1] <= den[k];
        neg[k+1] <= neg[k];
      end
    end
  end

  assign q_out   = q[QB];
  assign neg_out = neg[QB];

endmodule
